### sv/ledscan_pkg.sv
package ledscan_pkg;

	// default matrix geometry
	localparam int ROWS_DEF = 5;
	localparam int COLS_DEF = 14;

	// fixed field widths
	localparam int ROW_W  = 3;
	localparam int COL_W  = 4;
	localparam int CLR_W  = 2;
	localparam int DUTY_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// input operation codes
	typedef enum logic [1:0] {
		FUNC_TICK        = 2'd0,
		FUNC_LOAD_RADIAL = 2'd1,
		FUNC_LOAD_COL    = 2'd2,
		FUNC_LOAD_ROW    = 2'd3
	} func_t;

	// effect modes
	localparam logic [2:0] MODE_RADIAL  = 3'd0;
	localparam logic [2:0] MODE_HORIZ   = 3'd1;
	localparam logic [2:0] MODE_VERT    = 3'd2;
	localparam logic [2:0] MODE_SOLID   = 3'd3;
	localparam logic [2:0] MODE_BREATHE = 3'd4;
	localparam logic [2:0] MODE_OFF     = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRI   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd2;

	// configuration reset values
	localparam logic [2:0] MODE_RST  = MODE_RADIAL;
	localparam logic [7:0] BRI_RST   = 8'd255;
	localparam logic [4:0] SPEED_RST = 5'd4;

	// hue wheel segment bounds, half phase, duty full scale and colour count
	localparam logic [7:0] HUE_SEG1 = 8'd85;
	localparam logic [7:0] HUE_SEG2 = 8'd170;
	localparam logic [7:0] HALF_PHASE = 8'd128;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 11'd1024;
	localparam logic [CLR_W-1:0] NUM_COLORS = 2'd3;

	typedef struct packed {
		func_t            func;
		logic [ROW_W-1:0] row_index;
		logic [COL_W-1:0] col_index;
		logic [7:0]       hue_value;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  scan_row;
		logic [CLR_W-1:0]  scan_color;
		logic [COL_W-1:0]  column;
		logic [DUTY_W-1:0] duty;
		logic              last;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic             clr_wr;
		logic             load;
		logic             look;
		logic             calc;
		logic             wheel;
		logic             wr;
		logic [CLR_W-1:0] color;
		logic             adv_regen;
		logic             rd_issue;
		logic             out_load;
		logic             adv_scan;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic emit_en;
		logic col_last;
		logic out_free;
	} sts_t;

	// hue wheel: one 8-bit component per colour
	function automatic logic [23:0] hue_wheel(input logic [7:0] h);
		logic [7:0] d;
		logic [9:0] d3w;
		logic [7:0] d3;
		logic [23:0] rgb;
		if (h < HUE_SEG1) begin
			d = h;
		end else if (h < HUE_SEG2) begin
			d = h - HUE_SEG1;
		end else begin
			d = h - HUE_SEG2;
		end
		d3w = {2'b00, d} + {1'b0, d, 1'b0};
		d3 = d3w[7:0];
		if (h < HUE_SEG1) begin
			rgb = {8'd255 - d3, 8'd0, d3};
		end else if (h < HUE_SEG2) begin
			rgb = {8'd0, d3, 8'd255 - d3};
		end else begin
			rgb = {d3, 8'd255 - d3, 8'd0};
		end
		return rgb;
	endfunction

endpackage

### sv/rgb_led_matrix_effect_scanner_core.sv
// RGB LED matrix scanner with hue wheel effects. A scan tick (func 0) regenerates one
// pixel of the ROWS x 3 x COLS frame store from the effect mode, phase and brightness,
// advancing the phase by speed after each whole frame, and then, unless the mode is off,
// emits COLS column duties (1024 - 4 * value) for the current scan row and colour before
// moving the scan on, colour first. Hue table loads (func 1..3) are written as they are
// accepted and leave the block idle. A tick holds in_ready low through the regeneration
// sequence (table read, hue and brightness multiply, wheel, three frame store writes) and
// then, per column, a registered read of the single frame store read port, issued only
// when the output register is free, ahead of the output register load; in off mode a tick
// ends after the writes. After reset a clearing pass writes zero to all ROWS * 3 * COLS
// frame store entries (210 by default) before the first input is taken; configuration
// writes are accepted at all times and should be made while idle.
module rgb_led_matrix_effect_scanner_core #(
	parameter int ROWS = ledscan_pkg::ROWS_DEF,
	parameter int COLS = ledscan_pkg::COLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ledscan_pkg::in_item_t              in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ledscan_pkg::out_item_t             out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ledscan_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ledscan_pkg::CFG_DATA_W-1:0] cfg_data
);

	ledscan_pkg::cmd_t cmd;
	ledscan_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	ledscan_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tables, frame store, arithmetic and output register
	ledscan_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### sv/ledscan_ctrl.sv
module ledscan_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ledscan_pkg::func_t  in_func,
	output logic                in_ready,
	input  ledscan_pkg::sts_t   sts,
	output ledscan_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LOOK,
		S_CALC,
		S_WHEEL,
		S_WR0,
		S_WR1,
		S_WR2,
		S_RD,
		S_LD
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept && in_func == ledscan_pkg::FUNC_TICK) state_q <= S_LOOK;
				end
				S_LOOK:  state_q <= S_CALC;
				S_CALC:  state_q <= S_WHEEL;
				S_WHEEL: state_q <= S_WR0;
				S_WR0:   state_q <= S_WR1;
				S_WR1:   state_q <= S_WR2;
				S_WR2: begin
					state_q <= sts.emit_en ? S_RD : S_IDLE;
				end
				S_RD: begin
					if (sts.out_free) state_q <= S_LD;
				end
				S_LD: begin
					state_q <= sts.col_last ? S_IDLE : S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLR: cmd.clr_wr = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = accept && in_func != ledscan_pkg::FUNC_TICK;
			end
			S_LOOK:  cmd.look = 1'b1;
			S_CALC:  cmd.calc = 1'b1;
			S_WHEEL: cmd.wheel = 1'b1;
			S_WR0: begin
				cmd.wr = 1'b1;
				cmd.color = 2'd0;
			end
			S_WR1: begin
				cmd.wr = 1'b1;
				cmd.color = 2'd1;
			end
			S_WR2: begin
				cmd.wr = 1'b1;
				cmd.color = 2'd2;
				cmd.adv_regen = 1'b1;
				cmd.adv_scan = !sts.emit_en;
			end
			S_RD: cmd.rd_issue = sts.out_free;
			S_LD: begin
				cmd.out_load = 1'b1;
				cmd.adv_scan = sts.col_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

### sv/ledscan_dp.sv
module ledscan_dp #(
	parameter int ROWS = ledscan_pkg::ROWS_DEF,
	parameter int COLS = ledscan_pkg::COLS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ledscan_pkg::in_item_t                  in_data,
	input  logic                                   cfg_valid,
	input  logic [ledscan_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ledscan_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output ledscan_pkg::out_item_t                 out_data,
	input  ledscan_pkg::cmd_t                      cmd,
	output ledscan_pkg::sts_t                      sts
);

	localparam int FS_DEPTH  = ROWS * 3 * COLS;
	localparam int FS_AW     = $clog2(FS_DEPTH);
	localparam int RAD_DEPTH = ROWS * COLS;
	localparam int RAD_AW    = (RAD_DEPTH > 1) ? $clog2(RAD_DEPTH) : 1;
	localparam int CW        = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [ledscan_pkg::ROW_W-1:0] ROW_LAST = ledscan_pkg::ROW_W'(ROWS - 1);
	localparam logic [ledscan_pkg::COL_W-1:0] COL_LAST = ledscan_pkg::COL_W'(COLS - 1);

	// configuration registers
	logic [2:0] mode_q;
	logic [7:0] bri_q;
	logic [4:0] spd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ledscan_pkg::MODE_RST;
			bri_q  <= ledscan_pkg::BRI_RST;
			spd_q  <= ledscan_pkg::SPEED_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ledscan_pkg::CFG_MODE:  mode_q <= cfg_data[2:0];
				ledscan_pkg::CFG_BRI:   bri_q  <= cfg_data;
				ledscan_pkg::CFG_SPEED: spd_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// hue tables
	logic [7:0] rad_mem [RAD_DEPTH];
	logic [7:0] col_tbl [COLS];
	logic [7:0] row_tbl [ROWS];
	logic [7:0] rad_rd_s1;
	logic       row_ok;
	logic       col_ok;
	logic [RAD_AW-1:0] rad_waddr;
	logic [RAD_AW-1:0] rad_raddr;

	// regeneration pointers and phase
	logic [ledscan_pkg::ROW_W-1:0] rr_q;
	logic [ledscan_pkg::COL_W-1:0] rc_q;
	logic [7:0] phase_q;

	assign row_ok = int'(in_data.row_index) < ROWS;
	assign col_ok = int'(in_data.col_index) < COLS;
	assign rad_waddr = RAD_AW'(int'(in_data.row_index) * COLS + int'(in_data.col_index));
	assign rad_raddr = RAD_AW'(int'(rr_q) * COLS + int'(rc_q));

	// table writes and radial lookup
	always_ff @(posedge clk) begin
		if (cmd.load && in_data.func == ledscan_pkg::FUNC_LOAD_RADIAL && row_ok && col_ok) begin
			rad_mem[rad_waddr] <= in_data.hue_value;
		end
		if (cmd.look) begin
			rad_rd_s1 <= rad_mem[rad_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && in_data.func == ledscan_pkg::FUNC_LOAD_COL && col_ok) begin
			col_tbl[in_data.col_index[CW-1:0]] <= in_data.hue_value;
		end
		if (cmd.load && in_data.func == ledscan_pkg::FUNC_LOAD_ROW && row_ok) begin
			row_tbl[in_data.row_index[RW-1:0]] <= in_data.hue_value;
		end
	end

	// hue and brightness-scaled value
	logic [7:0]  hue_base;
	logic [7:0]  hue_next;
	logic [7:0]  tri_t;
	logic [7:0]  vsel;
	logic [15:0] vb_prod;
	logic [7:0]  hue_q;
	logic [7:0]  vb_q;

	always_comb begin
		tri_t = (phase_q >= ledscan_pkg::HALF_PHASE) ? (8'd255 - phase_q) : phase_q;
		unique case (mode_q)
			ledscan_pkg::MODE_HORIZ: hue_base = col_tbl[rc_q[CW-1:0]];
			ledscan_pkg::MODE_VERT:  hue_base = row_tbl[rr_q[RW-1:0]];
			default:                 hue_base = rad_rd_s1;
		endcase
		if (mode_q == ledscan_pkg::MODE_BREATHE) begin
			hue_next = {1'b0, phase_q[7:1]};
			vsel = {tri_t[6:0], 1'b0};
		end else begin
			hue_next = hue_base + phase_q;
			vsel = 8'd255;
		end
		vb_prod = vsel * bri_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			hue_q <= hue_next;
			vb_q  <= vb_prod[15:8];
		end
	end

	// wheel components
	logic [7:0] comp_q [3];
	logic [23:0] rgb;

	assign rgb = ledscan_pkg::hue_wheel(hue_q);

	always_ff @(posedge clk) begin
		if (cmd.wheel) begin
			comp_q[0] <= rgb[23:16];
			comp_q[1] <= rgb[15:8];
			comp_q[2] <= rgb[7:0];
		end
	end

	// pixel value for the colour being written
	logic [15:0] pix_prod;
	logic [7:0]  pix_val;

	always_comb begin
		pix_prod = comp_q[cmd.color] * vb_q;
		priority if (mode_q >= ledscan_pkg::MODE_OFF) begin
			pix_val = 8'd0;
		end else if (mode_q == ledscan_pkg::MODE_SOLID) begin
			pix_val = vb_q;
		end else begin
			pix_val = pix_prod[15:8];
		end
	end

	// regeneration pointer advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q    <= '0;
			rc_q    <= '0;
			phase_q <= '0;
		end else if (cmd.adv_regen) begin
			if (rc_q == COL_LAST) begin
				rc_q <= '0;
				if (rr_q == ROW_LAST) begin
					rr_q    <= '0;
					phase_q <= phase_q + {3'b000, spd_q};
				end else begin
					rr_q <= rr_q + 1'b1;
				end
			end else begin
				rc_q <= rc_q + 1'b1;
			end
		end
	end

	// clearing pass counter
	logic [FS_AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// scan pointers and emit column
	logic [ledscan_pkg::ROW_W-1:0] sr_q;
	logic [ledscan_pkg::CLR_W-1:0] sc_q;
	logic [ledscan_pkg::COL_W-1:0] ec_q;

	// frame store
	logic [7:0]       fs_mem [FS_DEPTH];
	logic [7:0]       fs_rd_s1;
	logic             fs_we;
	logic [FS_AW-1:0] fs_waddr;
	logic [7:0]       fs_wdata;
	logic [FS_AW-1:0] fs_raddr;

	always_comb begin
		if (cmd.clr_wr) begin
			fs_we    = 1'b1;
			fs_waddr = clr_q;
			fs_wdata = 8'd0;
		end else begin
			fs_we    = cmd.wr;
			fs_waddr = FS_AW'((int'(rr_q) * 3 + int'(cmd.color)) * COLS + int'(rc_q));
			fs_wdata = pix_val;
		end
		fs_raddr = FS_AW'((int'(sr_q) * 3 + int'(sc_q)) * COLS + int'(ec_q));
	end

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		if (cmd.rd_issue) begin
			fs_rd_s1 <= fs_mem[fs_raddr];
		end
	end

	// scan pointer advance and emit column count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q <= '0;
			sc_q <= '0;
			ec_q <= '0;
		end else begin
			if (cmd.out_load) begin
				ec_q <= (ec_q == COL_LAST) ? '0 : ec_q + 1'b1;
			end
			if (cmd.adv_scan) begin
				if (sc_q == ledscan_pkg::NUM_COLORS - 1'b1) begin
					sc_q <= '0;
					sr_q <= (sr_q == ROW_LAST) ? '0 : sr_q + 1'b1;
				end else begin
					sc_q <= sc_q + 1'b1;
				end
			end
		end
	end

	// output register
	logic out_valid_q;
	ledscan_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.scan_row   <= sr_q;
			out_q.scan_color <= sc_q;
			out_q.column     <= ec_q;
			out_q.duty       <= ledscan_pkg::DUTY_FULL - {1'b0, fs_rd_s1, 2'b00};
			out_q.last       <= ec_q == COL_LAST;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to controller
	assign sts.clr_last = clr_q == FS_AW'(FS_DEPTH - 1);
	assign sts.emit_en  = mode_q < ledscan_pkg::MODE_OFF;
	assign sts.col_last = ec_q == COL_LAST;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

### sv/ledscan_chk.sv
module ledscan_chk #(
	parameter int ROWS = ledscan_pkg::ROWS_DEF,
	parameter int COLS = ledscan_pkg::COLS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input ledscan_pkg::out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// duty is a multiple of four within range
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.duty[1:0] == 2'b00 && out_data.duty >= 11'd4
			&& out_data.duty <= ledscan_pkg::DUTY_FULL)
		else $error("duty out of range");

	// scan coordinates stay inside the matrix
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(out_data.column) < COLS && int'(out_data.scan_row) < ROWS
			&& out_data.scan_color != 2'd3)
		else $error("scan coordinate out of range");

	// no new input while a tick still has columns to emit
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> !in_ready)
		else $error("input taken in the middle of a column burst");

	// last flag marks the final column
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.last == (int'(out_data.column) == COLS - 1))
		else $error("last flag on wrong column");

endmodule

bind rgb_led_matrix_effect_scanner_core ledscan_chk #(
	.ROWS (ROWS),
	.COLS (COLS)
) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
